/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, status codes and the character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int JOB_DEPTH_LOG2_DEFAULT = 2;
   localparam int RSP_DEPTH_LOG2_DEFAULT = 2;

   typedef enum logic [2:0] {
      ST_OK              = 3'd0,
      ST_ILLEGAL         = 3'd1,
      ST_DIGIT_AFTER_PAD = 3'd2,
      ST_BAD_PAD         = 3'd3,
      ST_LONE_DIGIT      = 3'd4
   } status_type;

   // Character classes: values below CLS_SKIP are digit values.
   localparam logic [6:0] CLS_SKIP    = 7'd64;
   localparam logic [6:0] CLS_ILLEGAL = 7'd65;
   localparam logic [6:0] CLS_PAD     = 7'd66;

   // One unit of work for the back end: up to three data bytes and an optional status.
   typedef struct packed {
      logic        is_end;
      logic [1:0]  count;
      logic [23:0] data;
      status_type  status;
   } job_type;

   typedef struct packed {
      logic       is_end;
      logic [7:0] out_byte;
      status_type status;
   } rsp_type;

   function automatic logic [6:0] classify(input logic [7:0] ch);
      logic [6:0] cls;
      cls = CLS_ILLEGAL;
      if (ch inside {[8'h41:8'h5a]}) begin
         cls = 7'(ch - 8'h41);
      end else if (ch inside {[8'h61:8'h7a]}) begin
         cls = 7'(ch - 8'h61 + 8'd26);
      end else if (ch inside {[8'h30:8'h39]}) begin
         cls = 7'(ch - 8'h30 + 8'd52);
      end else if (ch inside {8'h2b, 8'h2d}) begin
         cls = 7'h3e;
      end else if (ch inside {8'h2f, 8'h5f}) begin
         cls = 7'h3f;
      end else if (ch == 8'h3d) begin
         cls = CLS_PAD;
      end else if (ch inside {8'h0a, 8'h0d}) begin
         cls = CLS_SKIP;
      end
      return cls;
   endfunction

endpackage

/* rtl/b64d_fifo.sv */
// ----------------------------------------------------------------------------
// Base64 decoder FIFO
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module b64d_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign full     = (count_ff == (DEPTH_LOG2 + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (DEPTH_LOG2 + 1)'(push_ok) - (DEPTH_LOG2 + 1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, tracks the digit group, padding and error
// state, and issues a job for every completed group and for every end request.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_op,
   input  logic [7:0]        req_character,
   output logic              req_full,
   output logic              job_push,
   output b64d_pkg::job_type job_data,
   input  logic              job_full
);

   import b64d_pkg::*;

   logic [5:0] held_ff [3];
   logic [5:0] held_in [3];
   logic [1:0] digit_count_ff, digit_count_in;
   logic [2:0] pad_count_ff, pad_count_in;
   status_type error_ff, error_in;
   logic       accept;
   logic [6:0] cls;
   logic [5:0] last_digit;
   logic [2:0] pad_expected;

   assign req_full     = job_full;
   assign accept       = req_push && !job_full;
   assign cls          = classify(req_character);
   assign pad_expected = 3'd4 - {1'b0, digit_count_ff};

   always_comb begin
      held_in        = held_ff;
      digit_count_in = digit_count_ff;
      pad_count_in   = pad_count_ff;
      error_in       = error_ff;
      job_push       = 1'b0;
      job_data.is_end = 1'b0;
      job_data.count  = 2'd0;
      job_data.status = ST_OK;
      last_digit      = (digit_count_ff == 2'd3) ? held_ff[2] : 6'd0;
      job_data.data   = {held_ff[0], held_ff[1], last_digit, cls[5:0]};

      if (accept) begin
         if (req_op) begin
            job_push        = 1'b1;
            job_data.is_end = 1'b1;
            job_data.data   = {held_ff[0], held_ff[1], last_digit, 6'd0};
            job_data.status = error_ff;
            if (error_ff == ST_OK) begin
               if (pad_count_ff != 3'd0 && pad_count_ff != pad_expected) begin
                  job_data.status = ST_BAD_PAD;
               end else if (digit_count_ff == 2'd1) begin
                  job_data.status = ST_LONE_DIGIT;
               end else if (digit_count_ff >= 2'd2) begin
                  job_data.count = digit_count_ff - 2'd1;
               end
            end
            digit_count_in = 2'd0;
            pad_count_in   = 3'd0;
            error_in       = ST_OK;
         end else if (error_ff == ST_OK) begin
            if (cls == CLS_ILLEGAL) begin
               error_in = ST_ILLEGAL;
            end else if (cls == CLS_PAD) begin
               if (pad_count_ff != 3'd7) begin
                  pad_count_in = pad_count_ff + 3'd1;
               end
            end else if (cls != CLS_SKIP) begin
               if (pad_count_ff != 3'd0) begin
                  error_in = ST_DIGIT_AFTER_PAD;
               end else if (digit_count_ff == 2'd3) begin
                  // Fourth digit completes the group: three bytes go to the back end.
                  job_push       = 1'b1;
                  job_data.count = 2'd3;
                  job_data.data  = {held_ff[0], held_ff[1], held_ff[2], cls[5:0]};
                  digit_count_in = 2'd0;
               end else begin
                  held_in[digit_count_ff] = cls[5:0];
                  digit_count_in          = digit_count_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= 2'd0;
         pad_count_ff   <= 3'd0;
         error_ff       <= ST_OK;
      end else begin
         digit_count_ff <= digit_count_in;
         pad_count_ff   <= pad_count_in;
         error_ff       <= error_in;
      end
   end

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Takes jobs from the job queue and writes their data bytes and final
// status into the result queue, one result per cycle while a job waits and the queue has room.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  b64d_pkg::job_type job_data,
   output logic              job_pop,
   output logic              res_push,
   output b64d_pkg::rsp_type res_data,
   input  logic              res_full
);

   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       step;
   logic       last;
   logic       is_data;

   assign step    = !job_empty && !res_full;
   assign is_data = (idx_ff != job_data.count);
   // An end job finishes on its status result, a group job on its third byte.
   assign last    = job_data.is_end ? !is_data : (idx_ff == job_data.count - 2'd1);
   assign job_pop  = step && last;
   assign res_push = step;

   always_comb begin
      res_data.is_end   = !is_data;
      res_data.status   = is_data ? ST_OK : job_data.status;
      case (idx_ff)
         2'd0:    res_data.out_byte = job_data.data[23:16];
         2'd1:    res_data.out_byte = job_data.data[15:8];
         default: res_data.out_byte = job_data.data[7:0];
      endcase
      if (!is_data) begin
         res_data.out_byte = 8'd0;
      end
      idx_in = idx_ff;
      if (step) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/base64_stream_decoder_core.sv */
// A request's results pass from the job queue through the back end into the result queue.
// Throughput: one request per cycle; the back end writes one result per cycle when not stalled.
// A group of four digits gives three results over four requests, so the back end keeps pace;
// the job queue absorbs the up to three results of an end request. Requests stall only
// when the job queue fills, that is when results back up or end requests outrun the back end.
// Reset (synchronous, active high) empties both queues and clears the decoder state.
// ----------------------------------------------------------------------------
// Base64 stream decoder core
// Decodes one base64 character per request into data bytes and a final status.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
   parameter int JOB_DEPTH_LOG2 = b64d_pkg::JOB_DEPTH_LOG2_DEFAULT,
   parameter int RSP_DEPTH_LOG2 = b64d_pkg::RSP_DEPTH_LOG2_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_op,
   input  logic [7:0] req_character,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_is_end,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status
);

   import b64d_pkg::*;

   job_type front_job;
   job_type head_job;
   rsp_type back_res;
   rsp_type head_res;
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;
   logic    res_push;
   logic    res_full;

   b64d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_op        (req_op),
      .req_character (req_character),
      .req_full      (req_full),
      .job_push      (job_push),
      .job_data      (front_job),
      .job_full      (job_full)
   );

   b64d_fifo #(
      .WIDTH      ($bits(job_type)),
      .DEPTH_LOG2 (JOB_DEPTH_LOG2)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (job_empty)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (head_job),
      .job_pop   (job_pop),
      .res_push  (res_push),
      .res_data  (back_res),
      .res_full  (res_full)
   );

   b64d_fifo #(
      .WIDTH      ($bits(rsp_type)),
      .DEPTH_LOG2 (RSP_DEPTH_LOG2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (head_res),
      .empty     (rsp_empty)
   );

   assign rsp_is_end   = head_res.is_end;
   assign rsp_out_byte = head_res.out_byte;
   assign rsp_status   = head_res.status;

endmodule

/* sim/b64d_decode_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 decoder result check
// Watches both queue interfaces of the decoder, works out the bytes and final
// status that each accepted request must produce, and compares them in order.
// ----------------------------------------------------------------------------
module b64d_decode_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_op,
   input  logic [7:0] req_character,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic       rsp_is_end,
   input  logic [7:0] rsp_out_byte,
   input  logic [2:0] rsp_status,
   output int         fail_count,
   output int         outstanding
);

   import b64d_pkg::*;

   typedef enum logic [1:0] {
      CH_DIGIT,
      CH_SKIP,
      CH_PAD,
      CH_BAD
   } char_kind_type;

   rsp_type    decoded_due[$];
   logic [5:0] group_digits[3];
   logic [1:0] digits_held;
   logic [2:0] pads_seen;
   status_type first_error;
   int         errors_found = 0;

   function automatic char_kind_type sort_char(input logic [7:0] ch, output logic [5:0] value);
      value = 6'd0;
      sort_char = CH_DIGIT;
      if (ch >= "A" && ch <= "Z") begin
         value = 6'(ch - "A");
      end else if (ch >= "a" && ch <= "z") begin
         value = 6'(ch - "a" + 8'd26);
      end else if (ch >= "0" && ch <= "9") begin
         value = 6'(ch - "0" + 8'd52);
      end else if (ch == "+" || ch == "-") begin
         value = 6'h3e;
      end else if (ch == "/" || ch == "_") begin
         value = 6'h3f;
      end else if (ch == "=") begin
         sort_char = CH_PAD;
      end else if (ch == 8'h0a || ch == 8'h0d) begin
         sort_char = CH_SKIP;
      end else begin
         sort_char = CH_BAD;
      end
   endfunction

   function automatic rsp_type data_byte(input logic [7:0] value);
      rsp_type r;
      r.is_end   = 1'b0;
      r.out_byte = value;
      r.status   = ST_OK;
      return r;
   endfunction

   function automatic void queue_result(input rsp_type r);
      decoded_due = {decoded_due, r};
   endfunction

   task automatic decode_request(input logic end_of_text, input logic [7:0] ch);
      logic [23:0]   triple;
      logic [5:0]    value;
      char_kind_type kind;
      status_type    st;
      rsp_type       fin;
      if (end_of_text) begin
         st = first_error;
         if (st == ST_OK) begin
            // The padding count is checked before a lone digit is reported.
            if (pads_seen != 3'd0 && int'(pads_seen) != 4 - int'(digits_held)) begin
               st = ST_BAD_PAD;
            end else if (digits_held == 2'd1) begin
               st = ST_LONE_DIGIT;
            end else if (digits_held >= 2'd2) begin
               triple = {group_digits[0], group_digits[1],
                         (digits_held == 2'd3) ? group_digits[2] : 6'd0, 6'd0};
               queue_result(data_byte(triple[23:16]));
               if (digits_held == 2'd3) begin
                  queue_result(data_byte(triple[15:8]));
               end
            end
         end
         fin.is_end   = 1'b1;
         fin.out_byte = 8'd0;
         fin.status   = st;
         queue_result(fin);
         digits_held  = 2'd0;
         pads_seen    = 3'd0;
         first_error  = ST_OK;
         group_digits = '{default: 6'd0};
      end else if (first_error == ST_OK) begin
         kind = sort_char(ch, value);
         case (kind)
            CH_BAD: begin
               first_error = ST_ILLEGAL;
            end
            CH_PAD: begin
               if (pads_seen != 3'd7) begin
                  pads_seen = pads_seen + 3'd1;
               end
            end
            CH_DIGIT: begin
               if (pads_seen != 3'd0) begin
                  first_error = ST_DIGIT_AFTER_PAD;
               end else if (digits_held == 2'd3) begin
                  triple = {group_digits[0], group_digits[1], group_digits[2], value};
                  queue_result(data_byte(triple[23:16]));
                  queue_result(data_byte(triple[15:8]));
                  queue_result(data_byte(triple[7:0]));
                  digits_held = 2'd0;
               end else begin
                  group_digits[digits_held] = value;
                  digits_held = digits_held + 2'd1;
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         decoded_due.delete();
         digits_held  = 2'd0;
         pads_seen    = 3'd0;
         first_error  = ST_OK;
         group_digits = '{default: 6'd0};
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (decoded_due.size() == 0) begin
               $error("unexpected result: is_end %0d out_byte %02h status %0d",
                      rsp_is_end, rsp_out_byte, rsp_status);
               errors_found++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_is_end !== want.is_end) begin
                  $error("is_end: expected %0d, got %0d", want.is_end, rsp_is_end);
                  errors_found++;
               end
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  errors_found++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors_found++;
               end
            end
         end
         if (req_push && !req_full) begin
            decode_request(req_op, req_character);
         end
      end
      fail_count  <= errors_found;
      outstanding <= decoded_due.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Sends directed and random base64 text, well formed and broken, under varying
// sender gaps and receiver stalls, and leaves the checking to the result check.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;
   localparam int   RANDOM_PER_PHASE = 18;
   localparam int   HOLD_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_op = 1'b0;
   logic [7:0] req_character = 8'd0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_is_end;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_status;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   bit hold_request = 1'b0;

   int idle_by_phase[4]  = '{0, 68, 0, 12};
   int stall_by_phase[4] = '{0, 0, 68, 12};

   always #2 clock = ~clock;

   base64_stream_decoder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_op        (req_op),
      .req_character (req_character),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_is_end    (rsp_is_end),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status)
   );

   b64d_decode_check decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_character (req_character),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_is_end    (rsp_is_end),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   function automatic logic [7:0] digit_char(input logic [5:0] value, input bit url);
      if (value < 6'd26) begin
         return "A" + 8'(value);
      end else if (value < 6'd52) begin
         return "a" + 8'(value - 6'd26);
      end else if (value < 6'd62) begin
         return "0" + 8'(value - 6'd52);
      end else if (value == 6'h3e) begin
         return url ? "-" : "+";
      end
      return url ? "_" : "/";
   endfunction

   task automatic send_item(input logic op, input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_op        <= op;
      req_character <= ch;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      int idx;
      for (idx = 0; idx < text.len(); idx++) begin
         send_item(OP_CHAR, text[idx]);
      end
      send_item(OP_END, 8'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed strings with random content; the rest is noise or
   // strings with one defect (stray padding, a digit after padding, a bad code).
   task automatic send_random_string();
      int  shape;
      int  digits;
      int  pads;
      int  idx;
      int  mishap;
      bit  url;
      shape = $urandom_range(0, 99);
      url   = 1'($urandom_range(0, 1));
      if (shape < 15) begin
         digits = $urandom_range(1, 8);
         for (idx = 0; idx < digits; idx++) begin
            if ($urandom_range(0, 1) != 0) begin
               send_item(OP_CHAR, 8'($urandom_range(0, 255)));
            end else begin
               send_item(OP_CHAR, digit_char(6'($urandom_range(0, 63)), url));
            end
         end
      end else begin
         digits = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
         pads   = 0;
         if (digits % 4 >= 2 && $urandom_range(0, 2) != 0) begin
            pads = 4 - digits % 4;
         end
         mishap = (shape >= 88) ? $urandom_range(1, 3) : 0;
         if (mishap == 1) begin
            pads = $urandom_range(1, 10);
         end
         for (idx = 0; idx < digits; idx++) begin
            if ($urandom_range(0, 11) == 0) begin
               send_item(OP_CHAR, ($urandom_range(0, 1) != 0) ? 8'h0a : 8'h0d);
            end
            if (mishap == 3 && idx == digits / 2) begin
               send_item(OP_CHAR, 8'($urandom_range(0, 255)));
            end
            send_item(OP_CHAR, digit_char(6'($urandom_range(0, 63)), url));
         end
         for (idx = 0; idx < pads; idx++) begin
            send_item(OP_CHAR, "=");
         end
         if (mishap == 2) begin
            send_item(OP_CHAR, digit_char(6'($urandom_range(0, 63)), url));
         end
      end
      send_item(OP_END, 8'($urandom_range(0, 255)));
   endtask

   // Receiver: random stalls, plus one long hold-off that lets the decoder fill up.
   initial begin : receiver
      int hold_count;
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_pop     <= 1'b0;
            hold_served = 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(posedge clock);
            end
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      int phase;
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full-scale bytes mixing the standard and URL alphabets, unused bits set in the last digit,
      // skipped line breaks before a lone digit, a code above 127 followed by an
      // ignored digit, a digit after padding, and four pads with no digits.
      send_text("//__");
      send_text("QR==");
      send_item(OP_CHAR, 8'h0a);
      send_item(OP_CHAR, 8'h0d);
      send_item(OP_CHAR, "A");
      send_item(OP_END, 8'h00);
      send_item(OP_CHAR, 8'hff);
      send_item(OP_CHAR, "A");
      send_item(OP_END, 8'h00);
      send_text("=A");
      send_text("====");

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         stall_pct    <= stall_by_phase[phase];
         if (phase == 0) begin
            hold_request <= 1'b1;
         end
         target = items_sent + RANDOM_PER_PHASE;
         while (items_sent < target) begin
            send_random_string();
         end
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #400us;
      $display("tb: failure");
      $finish;
   end

endmodule
